// ===== hw/rtl/rqrst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqrst_pkg
// Shared types and character constants for the R quote and raw string tracker.
// ----------------------------------------------------------------------------
package rqrst_pkg;

   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_BACKTICK  = 8'h60;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UPPER_R   = 8'h52;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;

   typedef enum logic [1:0] {
      PHASE_NONE  = 2'd0,
      PHASE_SAW_R = 2'd1,
      PHASE_QUOTE = 2'd2,
      PHASE_BODY  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DELIM_NONE    = 2'd0,
      DELIM_PAREN   = 2'd1,
      DELIM_BRACKET = 2'd2,
      DELIM_BRACE   = 2'd3
   } delim_type;

   typedef struct packed {
      logic      single_q;
      logic      double_q;
      logic      backtick;
      logic      escape;
      logic      raw;
      phase_type phase;
      delim_type open_delim;
   } flags_type;

endpackage : rqrst_pkg
`default_nettype wire

// ===== hw/rtl/rqrst_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqrst_req_if / rqrst_rsp_if
// Valid/ready channels for input bytes and per-byte context results.
// ----------------------------------------------------------------------------
interface rqrst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface : rqrst_req_if

interface rqrst_rsp_if;
   logic       valid;
   logic       ready;
   logic       in_single;
   logic       in_double;
   logic       in_backtick;
   logic       escape_pending;
   logic       in_raw;
   logic [1:0] raw_phase;

   modport source (output valid, output in_single, output in_double, output in_backtick,
                   output escape_pending, output in_raw, output raw_phase, input ready);
   modport sink   (input valid, input in_single, input in_double, input in_backtick,
                   input escape_pending, input in_raw, input raw_phase, output ready);
endinterface : rqrst_rsp_if
`default_nettype wire

// ===== hw/rtl/rqrst_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqrst_step
// Next-state logic for one byte: raw string scan, prefix scan, plain scan.
// ----------------------------------------------------------------------------
module rqrst_step #(
   parameter int DASH_W     = 8,
   parameter int MAX_DASHES = 255
) (
   input  wire logic [7:0]         ch,
   input  wire rqrst_pkg::flags_type cur,
   input  wire logic [DASH_W-1:0]  stored_cur,
   input  wire logic [DASH_W-1:0]  count_cur,
   output rqrst_pkg::flags_type    nxt,
   output logic [DASH_W-1:0]       stored_nxt,
   output logic [DASH_W-1:0]       count_nxt
);
   import rqrst_pkg::*;

   localparam logic [DASH_W-1:0] DashMax = DASH_W'(MAX_DASHES);

   logic consumed;
   logic closer;
   logic is_open;

   always_comb begin
      unique case (cur.open_delim)
         DELIM_PAREN:   closer = (ch == CH_RPAREN);
         DELIM_BRACKET: closer = (ch == CH_RBRACKET);
         DELIM_BRACE:   closer = (ch == CH_RBRACE);
         default:       closer = 1'b0;
      endcase
      is_open = (ch == CH_LPAREN) || (ch == CH_LBRACKET) || (ch == CH_LBRACE);
   end

   always_comb begin
      nxt        = cur;
      stored_nxt = stored_cur;
      count_nxt  = count_cur;
      consumed   = 1'b0;

      if (cur.raw) begin
         if (cur.phase == PHASE_BODY) begin
            if (closer) nxt.phase = PHASE_QUOTE;
         end else if (cur.phase == PHASE_QUOTE) begin
            if (count_cur == '0) begin
               priority if (cur.single_q && ch == CH_SQUOTE) begin
                  nxt.single_q = 1'b0;
                  nxt.raw      = 1'b0;
                  nxt.phase    = PHASE_NONE;
               end else if (cur.double_q && ch == CH_DQUOTE) begin
                  nxt.double_q = 1'b0;
                  nxt.raw      = 1'b0;
                  nxt.phase    = PHASE_NONE;
               end else begin
                  count_nxt = stored_cur;
                  nxt.phase = PHASE_BODY;
               end
            end else if (ch == CH_DASH) begin
               count_nxt = count_cur - 1'b1;
            end else begin
               count_nxt = stored_cur;
               nxt.phase = PHASE_BODY;
            end
         end
      end else begin
         if (cur.phase == PHASE_SAW_R) begin
            priority if (ch == CH_SQUOTE) begin
               nxt.phase    = PHASE_QUOTE;
               nxt.single_q = 1'b1;
               count_nxt    = '0;
               consumed     = 1'b1;
            end else if (ch == CH_DQUOTE) begin
               nxt.phase    = PHASE_QUOTE;
               nxt.double_q = 1'b1;
               count_nxt    = '0;
               consumed     = 1'b1;
            end else begin
               nxt.phase    = PHASE_NONE;
               nxt.single_q = 1'b0;
               nxt.double_q = 1'b0;
            end
         end else if (cur.phase == PHASE_QUOTE) begin
            consumed = 1'b1;
            priority if (is_open) begin
               nxt.phase  = PHASE_BODY;
               stored_nxt = count_cur;
               nxt.raw    = 1'b1;
               nxt.open_delim = (ch == CH_LPAREN)   ? DELIM_PAREN :
                                (ch == CH_LBRACKET) ? DELIM_BRACKET : DELIM_BRACE;
            end else if (ch == CH_DASH) begin
               if (count_cur < DashMax) count_nxt = count_cur + 1'b1;
            end else begin
               nxt.phase    = PHASE_NONE;
               nxt.single_q = 1'b0;
               nxt.double_q = 1'b0;
            end
         end

         if (!consumed) begin
            priority if (nxt.escape) begin
               nxt.escape = 1'b0;
            end else if (nxt.backtick && ch == CH_BACKTICK) begin
               nxt.backtick = 1'b0;
            end else if (nxt.single_q && ch == CH_SQUOTE) begin
               nxt.single_q = 1'b0;
            end else if (nxt.double_q && ch == CH_DQUOTE) begin
               nxt.double_q = 1'b0;
            end else if (ch == CH_UPPER_R || ch == CH_LOWER_R) begin
               nxt.phase = PHASE_SAW_R;
            end else if (ch == CH_BACKSLASH) begin
               nxt.escape = 1'b1;
            end else if (nxt.single_q || nxt.double_q || nxt.backtick) begin
               nxt.escape = 1'b0;
            end else if (ch == CH_BACKTICK) begin
               nxt.backtick = 1'b1;
            end else if (ch == CH_SQUOTE) begin
               nxt.single_q = 1'b1;
            end else begin
               nxt.double_q = (ch == CH_DQUOTE);
            end
         end
      end
   end

endmodule : rqrst_step
`default_nettype wire

// ===== hw/rtl/r_quote_and_raw_string_tracker.sv =====
`default_nettype none
// Scans R source text one byte per beat and reports, for each byte, the quote,
// escape and raw string context after it. A byte is taken into an input
// register, the context update runs combinationally from there into the result
// register, so a new byte is accepted every cycle and each result is presented
// once its byte has passed the input register; the only stall is the result
// side. Raw string dash runs count up to MAX_DASHES and stay there.
// ----------------------------------------------------------------------------
// r_quote_and_raw_string_tracker
// Top level: input register, context state, result register and handshakes.
// ----------------------------------------------------------------------------
module r_quote_and_raw_string_tracker #(
   parameter int MAX_DASHES = 255
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rqrst_req_if.sink   req_bus,
   rqrst_rsp_if.source rsp_bus
);
   import rqrst_pkg::*;

   localparam int DASH_W = $clog2(MAX_DASHES + 1);

   logic                in_valid_ff;
   logic [7:0]          in_ch_ff;
   logic                out_valid_ff;
   flags_type           out_flags_ff;
   flags_type           state_ff;
   logic [DASH_W-1:0]   stored_ff;
   logic [DASH_W-1:0]   count_ff;

   flags_type           state_in;
   logic [DASH_W-1:0]   stored_in;
   logic [DASH_W-1:0]   count_in;

   logic advance;
   logic fire;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   rqrst_step #(
      .DASH_W     (DASH_W),
      .MAX_DASHES (MAX_DASHES)
   ) u_step (
      .ch         (in_ch_ff),
      .cur        (state_ff),
      .stored_cur (stored_ff),
      .count_cur  (count_ff),
      .nxt        (state_in),
      .stored_nxt (stored_in),
      .count_nxt  (count_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         stored_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (req_bus.ready) in_valid_ff <= req_bus.valid;
         if (advance) out_valid_ff <= in_valid_ff;
         if (fire) begin
            state_ff  <= state_in;
            stored_ff <= stored_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) in_ch_ff <= req_bus.ch;
      if (fire) out_flags_ff <= state_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.in_single      = out_flags_ff.single_q;
   assign rsp_bus.in_double      = out_flags_ff.double_q;
   assign rsp_bus.in_backtick    = out_flags_ff.backtick;
   assign rsp_bus.escape_pending = out_flags_ff.escape;
   assign rsp_bus.in_raw         = out_flags_ff.raw;
   assign rsp_bus.raw_phase      = out_flags_ff.phase;

   a_raw_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.raw |-> (state_ff.phase == PHASE_QUOTE || state_ff.phase == PHASE_BODY))
      else $error("raw flag set outside quote or body phase");

   a_raw_delim: assert property (@(posedge clock) disable iff (reset)
      state_ff.raw |-> (state_ff.open_delim != DELIM_NONE))
      else $error("raw string without an opening delimiter");

   a_dash_sat: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= DASH_W'(MAX_DASHES)) && (stored_ff <= DASH_W'(MAX_DASHES)))
      else $error("dash count beyond saturation limit");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff) && $stable(count_ff))
      else $error("context state changed without a byte");

   a_rsp_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> (out_flags_ff == state_ff) && out_valid_ff)
      else $error("result does not match updated context");

endmodule : r_quote_and_raw_string_tracker
`default_nettype wire

// ===== verif/r_quote_and_raw_string_tracker_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// r_quote_and_raw_string_tracker_tb
// Drives source bytes through the tracker and checks every context beat against
// a table value or a cycle-free predictor of the quote, escape and raw string
// rules. A short table covers extremes and the odd prefix and closing cases;
// random fragments of raw strings, quoted text, broken prefixes and noise follow,
// with random stalls on both channels, one long result hold-off and drains.
// ----------------------------------------------------------------------------
module r_quote_and_raw_string_tracker_tb;
   import rqrst_pkg::*;

   localparam int MAX_DASHES = 255;
   localparam logic [7:0] CH_X = 8'h78;

   typedef struct packed {
      logic      single_q;
      logic      double_q;
      logic      backtick;
      logic      escape;
      logic      raw;
      phase_type phase;
   } context_flags_type;

   typedef struct {
      logic       single_q;
      logic       double_q;
      logic       backtick;
      logic       escape;
      logic       raw;
      phase_type  phase;
      logic [7:0] stored_dashes;
      logic [7:0] dash_count;
      delim_type  open_delim;
   } scan_state_type;

   typedef struct {
      logic [7:0]        ch;
      bit                typed;
      context_flags_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   rqrst_req_if req_bus ();
   rqrst_rsp_if rsp_bus ();

   r_quote_and_raw_string_tracker #(
      .MAX_DASHES(MAX_DASHES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   scan_state_type    scan_state;
   context_flags_type expected_ctx_q [$];
   int                bytes_sent   = 0;
   int                results_seen = 0;
   int                fail_count   = 0;
   bit                idle_on      = 1'b1;
   bit                hold_request = 1'b0;
   int                hold_left    = 0;
   int                stall_left   = 0;
   context_flags_type want_ctx;

   logic [7:0] text_specials [13] = '{CH_RPAREN, CH_RBRACKET, CH_RBRACE, CH_DASH, CH_SQUOTE,
                                      CH_DQUOTE, CH_BACKTICK, CH_BACKSLASH, CH_UPPER_R,
                                      CH_LOWER_R, CH_LPAREN, CH_LBRACKET, CH_LBRACE};

   // want = {single, double, backtick, escape, raw, phase}
   stim_row_type directed_rows [28] = '{
      '{8'h00,        1'b1, 7'b0_0_0_0_0_00},
      '{8'hFF,        1'b1, 7'b0_0_0_0_0_00},
      '{CH_DQUOTE,    1'b1, 7'b0_1_0_0_0_00},
      '{CH_LOWER_R,   1'b1, 7'b0_1_0_0_0_01},
      '{CH_X,         1'b1, 7'b0_0_0_0_0_00},
      '{CH_BACKTICK,  1'b1, 7'b0_0_1_0_0_00},
      '{CH_BACKSLASH, 1'b1, 7'b0_0_1_1_0_00},
      '{CH_BACKTICK,  1'b1, 7'b0_0_1_0_0_00},
      '{CH_BACKTICK,  1'b1, 7'b0_0_0_0_0_00},
      '{CH_UPPER_R,   1'b1, 7'b0_0_0_0_0_01},
      '{CH_SQUOTE,    1'b1, 7'b1_0_0_0_0_10},
      '{CH_DASH,      1'b0, 7'b0},
      '{CH_LPAREN,    1'b1, 7'b1_0_0_0_1_11},
      '{CH_RPAREN,    1'b0, 7'b0},
      '{CH_X,         1'b0, 7'b0},
      '{CH_RPAREN,    1'b0, 7'b0},
      '{CH_DASH,      1'b0, 7'b0},
      '{CH_SQUOTE,    1'b1, 7'b0_0_0_0_0_00},
      '{CH_LOWER_R,   1'b1, 7'b0_0_0_0_0_01},
      '{CH_DQUOTE,    1'b1, 7'b0_1_0_0_0_10},
      '{CH_LBRACKET,  1'b0, 7'b0},
      '{CH_RBRACKET,  1'b0, 7'b0},
      '{CH_RBRACE,    1'b0, 7'b0},
      '{CH_RBRACKET,  1'b0, 7'b0},
      '{CH_DQUOTE,    1'b1, 7'b0_0_0_0_0_00},
      '{CH_UPPER_R,   1'b0, 7'b0},
      '{CH_DQUOTE,    1'b0, 7'b0},
      '{CH_X,         1'b1, 7'b0_0_0_0_0_00}
   };

   function automatic context_flags_type advance_context(input logic [7:0] c);
      logic consumed;
      consumed = 1'b0;
      if (scan_state.raw) begin
         if (scan_state.phase == PHASE_BODY) begin
            if ((scan_state.open_delim == DELIM_PAREN && c == CH_RPAREN) ||
                (scan_state.open_delim == DELIM_BRACKET && c == CH_RBRACKET) ||
                (scan_state.open_delim == DELIM_BRACE && c == CH_RBRACE)) begin
               scan_state.phase = PHASE_QUOTE;
            end
         end else if (scan_state.phase == PHASE_QUOTE) begin
            if (scan_state.dash_count == 8'd0) begin
               if (scan_state.single_q && c == CH_SQUOTE) begin
                  scan_state.single_q = 1'b0;
                  scan_state.raw      = 1'b0;
                  scan_state.phase    = PHASE_NONE;
               end else if (scan_state.double_q && c == CH_DQUOTE) begin
                  scan_state.double_q = 1'b0;
                  scan_state.raw      = 1'b0;
                  scan_state.phase    = PHASE_NONE;
               end else begin
                  scan_state.dash_count = scan_state.stored_dashes;
                  scan_state.phase      = PHASE_BODY;
               end
            end else if (c == CH_DASH) begin
               scan_state.dash_count = scan_state.dash_count - 8'd1;
            end else begin
               scan_state.dash_count = scan_state.stored_dashes;
               scan_state.phase      = PHASE_BODY;
            end
         end
      end else begin
         if (scan_state.phase == PHASE_SAW_R) begin
            if (c == CH_SQUOTE || c == CH_DQUOTE) begin
               scan_state.phase      = PHASE_QUOTE;
               scan_state.dash_count = 8'd0;
               if (c == CH_SQUOTE) scan_state.single_q = 1'b1;
               else scan_state.double_q = 1'b1;
               consumed = 1'b1;
            end else begin
               scan_state.phase    = PHASE_NONE;
               scan_state.single_q = 1'b0;
               scan_state.double_q = 1'b0;
            end
         end else if (scan_state.phase == PHASE_QUOTE) begin
            consumed = 1'b1;
            if (c == CH_LPAREN || c == CH_LBRACKET || c == CH_LBRACE) begin
               scan_state.phase         = PHASE_BODY;
               scan_state.stored_dashes = scan_state.dash_count;
               scan_state.open_delim    = (c == CH_LPAREN) ? DELIM_PAREN :
                                          (c == CH_LBRACKET) ? DELIM_BRACKET : DELIM_BRACE;
               scan_state.raw           = 1'b1;
            end else if (c == CH_DASH) begin
               if (int'(scan_state.dash_count) < MAX_DASHES)
                  scan_state.dash_count = scan_state.dash_count + 8'd1;
            end else begin
               scan_state.phase    = PHASE_NONE;
               scan_state.single_q = 1'b0;
               scan_state.double_q = 1'b0;
            end
         end
         if (!consumed) begin
            if (scan_state.escape) begin
               scan_state.escape = 1'b0;
            end else if (scan_state.backtick && c == CH_BACKTICK) begin
               scan_state.backtick = 1'b0;
            end else if (scan_state.single_q && c == CH_SQUOTE) begin
               scan_state.single_q = 1'b0;
            end else if (scan_state.double_q && c == CH_DQUOTE) begin
               scan_state.double_q = 1'b0;
            end else if (c == CH_UPPER_R || c == CH_LOWER_R) begin
               scan_state.phase = PHASE_SAW_R;
            end else if (c == CH_BACKSLASH) begin
               scan_state.escape = 1'b1;
            end else if (scan_state.single_q || scan_state.double_q || scan_state.backtick) begin
               // quoted text: no change
            end else if (c == CH_BACKTICK) begin
               scan_state.backtick = 1'b1;
            end else if (c == CH_SQUOTE) begin
               scan_state.single_q = 1'b1;
            end else if (c == CH_DQUOTE) begin
               scan_state.double_q = 1'b1;
            end
         end
      end
      return '{scan_state.single_q, scan_state.double_q, scan_state.backtick,
               scan_state.escape, scan_state.raw, scan_state.phase};
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
      fail_count++;
   endtask

   task automatic send_byte(input logic [7:0] c, input bit typed = 1'b0,
                            input context_flags_type want = '0);
      context_flags_type predicted;
      req_bus.valid <= 1'b1;
      req_bus.ch    <= c;
      do @(posedge clock); while (!req_bus.ready);
      predicted = advance_context(c);
      expected_ctx_q.push_back(typed ? want : predicted);
      bytes_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (expected_ctx_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [7:0] body_char();
      if ($urandom_range(0, 9) < 6) return text_specials[$urandom_range(0, 12)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic emit_raw_string(input int dashes, input bit broken);
      logic [7:0] quote;
      logic [7:0] open_ch;
      logic [7:0] close_ch;
      int         kind;
      int         close_dashes;
      close_dashes = (dashes > MAX_DASHES) ? MAX_DASHES : dashes;
      kind         = $urandom_range(0, 2);
      open_ch      = (kind == 0) ? CH_LPAREN : (kind == 1) ? CH_LBRACKET : CH_LBRACE;
      close_ch     = (kind == 0) ? CH_RPAREN : (kind == 1) ? CH_RBRACKET : CH_RBRACE;
      quote        = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      send_byte($urandom_range(0, 1) ? CH_UPPER_R : CH_LOWER_R);
      send_byte(quote);
      repeat (dashes) send_byte(CH_DASH);
      send_byte(open_ch);
      repeat ($urandom_range(0, 6)) send_byte(body_char());
      send_byte(close_ch);
      if (broken) begin
         repeat ($urandom_range(0, close_dashes)) send_byte(CH_DASH);
         repeat ($urandom_range(1, 4)) send_byte(body_char());
         send_byte(close_ch);
      end
      repeat (close_dashes) send_byte(CH_DASH);
      send_byte(quote);
   endtask

   task automatic emit_fragment();
      int         pick;
      int         kind;
      logic [7:0] quote;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         emit_raw_string($urandom_range(0, 9) == 0 ? $urandom_range(4, 12) : $urandom_range(0, 3),
                         pick >= 45);
      end else if (pick < 75) begin
         kind  = $urandom_range(0, 2);
         quote = (kind == 0) ? CH_SQUOTE : (kind == 1) ? CH_DQUOTE : CH_BACKTICK;
         send_byte(quote);
         repeat ($urandom_range(0, 6)) send_byte(body_char());
         send_byte(quote);
      end else if (pick < 85) begin
         send_byte($urandom_range(0, 1) ? CH_UPPER_R : CH_LOWER_R);
         if ($urandom_range(0, 1)) begin
            send_byte(8'($urandom_range(8'h30, 8'h7E)));
         end else begin
            send_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
            repeat ($urandom_range(0, 3)) send_byte(CH_DASH);
            send_byte(8'($urandom_range(8'h30, 8'h5A)));
         end
      end else begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_random(input int upto, input bit vary_idle);
      while (bytes_sent < upto) begin
         emit_fragment();
         if (vary_idle && $urandom_range(0, 19) == 0) idle_on = ~idle_on;
      end
   endtask

   // result side: check, then pick next ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_ctx_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want_ctx = expected_ctx_q.pop_front();
               if (rsp_bus.in_single !== want_ctx.single_q)
                  report_mismatch("in_single", rsp_bus.in_single, want_ctx.single_q);
               if (rsp_bus.in_double !== want_ctx.double_q)
                  report_mismatch("in_double", rsp_bus.in_double, want_ctx.double_q);
               if (rsp_bus.in_backtick !== want_ctx.backtick)
                  report_mismatch("in_backtick", rsp_bus.in_backtick, want_ctx.backtick);
               if (rsp_bus.escape_pending !== want_ctx.escape)
                  report_mismatch("escape_pending", rsp_bus.escape_pending, want_ctx.escape);
               if (rsp_bus.in_raw !== want_ctx.raw)
                  report_mismatch("in_raw", rsp_bus.in_raw, want_ctx.raw);
               if (rsp_bus.raw_phase !== want_ctx.phase)
                  report_mismatch("raw_phase", rsp_bus.raw_phase, want_ctx.phase);
            end
            results_seen++;
         end
         if (hold_request) begin
            hold_left    = 50;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.ch    <= 8'h00;
      scan_state = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PHASE_NONE, 8'd0, 8'd0, DELIM_NONE};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      // opening dash run past saturation
      emit_raw_string(300, 1'b0);
      run_random(700, 1'b1);

      hold_request = 1'b1;
      run_random(800, 1'b1);
      drain_results();

      run_random(1150, 1'b1);
      idle_on = 1'b0;
      run_random(1400, 1'b0);

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_ctx_q.size() != 0)
         report_mismatch("missing results", 0, expected_ctx_q.size());
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule : r_quote_and_raw_string_tracker_tb
`default_nettype wire

// ===== r_quote_and_raw_string_tracker.f =====
hw/rtl/rqrst_pkg.sv
hw/rtl/rqrst_if.sv
hw/rtl/rqrst_step.sv
hw/rtl/r_quote_and_raw_string_tracker.sv
verif/r_quote_and_raw_string_tracker_tb.sv
